// File: hw/rtl/mmcs_pkg.sv
// ---------------------------------------------------------------------------
// mmcs_pkg: shared types and constants for the contrast stretch block
// Payload structs, register indexes, status codes, controller commands and datapath status.
// ---------------------------------------------------------------------------
`default_nettype none
package mmcs_pkg;

    localparam int unsigned FRAME_PIXELS_DEF = 65536;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GREY   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_COUNT    = 3'd2;
    localparam logic [2:0] ST_FLAT     = 3'd3;
    localparam logic [2:0] ST_NO_FRAME = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_value;
        logic        end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic        is_pixel;
        logic [7:0]  scaled_value;
        logic [15:0] pixel_index;
        logic [2:0]  status;
        logic        last_pixel;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture load item (update stats, write store)
        logic close;     // compute status for captured end of frame
        logic rd;        // issue store read for drain
        logic div_start; // start divider on read data
        logic nofr;      // emit "no frame" status
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic can_drain;
        logic div_done;
    } dp_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/mmcs_ctrl.sv
// ---------------------------------------------------------------------------
// mmcs_ctrl: sequencing controller
// Decodes a started transaction and steps the datapath through load, close
// or drain (read, divide, emit), or commands a no-frame status.
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mmcs_pkg::in_item_t item,
    input  wire mmcs_pkg::dp_sts_t  sts,
    output mmcs_pkg::dp_cmd_t     cmd,
    output logic                  busy
);
    import mmcs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CLOSE, S_READ, S_DIVST, S_DIV} state_t;

    state_t    state_reg, state_next;
    dp_cmd_t   cmd_next;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    if (!item.kind)
                    begin
                        cmd_next.load = 1'b1;
                        if (item.end_of_frame)
                            state_next = S_CLOSE;
                    end
                    else if (sts.can_drain)
                    begin
                        cmd_next.rd = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                        cmd_next.nofr = 1'b1;
                end
            end
            S_CLOSE:
            begin
                cmd_next.close = 1'b1;
                state_next     = S_IDLE;
            end
            S_READ:
            begin
                cmd_next.div_start = 1'b1;
                state_next         = S_DIVST;
            end
            S_DIVST:
                state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd       <= cmd_next;
        end
    end

    // busy covers the cycle the registered command is executing
    assign busy = (state_reg != S_IDLE) || (cmd != '0);

endmodule
`default_nettype wire

// File: hw/rtl/mmcs_dp.sv
// ---------------------------------------------------------------------------
// mmcs_dp: datapath
// Frame store, running statistics, status evaluation and a restoring divider
// for round(255*n/d).
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_dp #(
    parameter int unsigned FRAME_PIXELS = mmcs_pkg::FRAME_PIXELS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mmcs_pkg::in_item_t  item,
    input  wire mmcs_pkg::dp_cmd_t   cmd,
    input  wire logic [10:0]        frame_width,
    input  wire logic [10:0]        frame_height,
    input  wire logic [8:0]         max_grey_value,
    output mmcs_pkg::dp_sts_t        sts,
    output logic                    result_valid,
    output mmcs_pkg::out_item_t      result
);
    import mmcs_pkg::*;

    localparam int AW = $clog2(FRAME_PIXELS);
    localparam int CW = $clog2(FRAME_PIXELS + 2);

    logic [7:0]  mem [FRAME_PIXELS];
    logic [7:0]  rd_data_reg;

    logic [7:0]    min_reg, max_reg;
    logic [CW-1:0] cnt_reg;
    logic          verr_reg, ready_reg, closed_reg;
    logic [CW-1:0] ridx_reg;
    logic [15:0]   pix_reg;

    // divider: quotient of (510*n + d) / (2d), 17-bit numerator
    logic [16:0] num_reg;
    logic [9:0]  den_reg;
    logic [9:0]  rem_reg;
    logic [8:0]  quo_reg;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [CW-1:0] oidx_reg;

    logic [7:0]  limit;
    logic        good;
    logic [21:0] area;
    logic [10:0] rem_sh;

    assign limit      = max_grey_value[8] ? 8'hFF : max_grey_value[7:0];
    assign area       = 22'(frame_width) * 22'(frame_height);

    assign sts.can_drain = ready_reg && (ridx_reg < cnt_reg)
                         && (ridx_reg < CW'(FRAME_PIXELS)) && (max_reg > min_reg);
    assign sts.div_done  = dbusy_reg && (dcnt_reg == 5'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load && !(closed_reg) && (item.pixel_value <= {8'd0, limit})
            && (cnt_reg < CW'(FRAME_PIXELS)))
            mem[cnt_reg[AW-1:0]] <= item.pixel_value[7:0];
        else if (cmd.load && closed_reg && (item.pixel_value <= {8'd0, limit}))
            mem[0] <= item.pixel_value[7:0];
        if (cmd.rd)
            rd_data_reg <= mem[ridx_reg[AW-1:0]];
    end

    assign pix_reg = item.pixel_value;
    assign good    = (pix_reg <= {8'd0, limit});
    assign rem_sh  = {rem_reg, num_reg[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= 8'hFF; max_reg <= '0; cnt_reg <= '0; verr_reg <= 1'b0;
            ready_reg <= 1'b0; closed_reg <= 1'b0; ridx_reg <= '0;
            dbusy_reg <= 1'b0; dcnt_reg <= '0; result_valid <= 1'b0;
            result <= '0; num_reg <= '0; den_reg <= '0; rem_reg <= '0;
            quo_reg <= '0; oidx_reg <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cmd.load)
            begin
                if (closed_reg)
                begin
                    ready_reg  <= 1'b0;
                    closed_reg <= 1'b0;
                    ridx_reg   <= '0;
                    verr_reg   <= !good;
                    min_reg    <= good ? pix_reg[7:0] : 8'hFF;
                    max_reg    <= good ? pix_reg[7:0] : 8'h00;
                    cnt_reg    <= CW'(1);
                end
                else
                begin
                    if (!good)
                        verr_reg <= 1'b1;
                    else
                    begin
                        if (pix_reg[7:0] < min_reg) min_reg <= pix_reg[7:0];
                        if (pix_reg[7:0] > max_reg) max_reg <= pix_reg[7:0];
                    end
                    if (cnt_reg <= CW'(FRAME_PIXELS))
                        cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.close)
            begin
                result_valid <= 1'b1;
                closed_reg   <= 1'b1;
                ridx_reg     <= '0;
                if (verr_reg)
                    result <= '{1'b0, 8'd0, 16'd0, ST_RANGE, 1'b0};
                else if ({{(32-CW){1'b0}}, cnt_reg} != {10'd0, area})
                    result <= '{1'b0, 8'd0, 16'd0, ST_COUNT, 1'b0};
                else if (max_reg == min_reg)
                    result <= '{1'b0, 8'd0, 16'd0, ST_FLAT, 1'b0};
                else
                begin
                    result    <= '{1'b0, 8'd0, 16'd0, ST_OK, 1'b0};
                    ready_reg <= 1'b1;
                end
            end
            if (cmd.nofr)
            begin
                result_valid <= 1'b1;
                result       <= '{1'b0, 8'd0, 16'd0, ST_NO_FRAME, 1'b0};
            end
            if (cmd.div_start)
            begin
                // numerator = 510*n + d ; denominator = 2d
                num_reg   <= 17'(10'd510 * ((rd_data_reg >= min_reg) ?
                              (rd_data_reg - min_reg) : 8'd0)) + 17'(max_reg - min_reg);
                den_reg   <= {1'b0, max_reg - min_reg, 1'b0};
                rem_reg   <= '0;
                quo_reg   <= '0;
                dcnt_reg  <= 5'd17;
                dbusy_reg <= 1'b1;
                oidx_reg  <= ridx_reg;
            end
            else if (dbusy_reg && dcnt_reg != 5'd0)
            begin
                num_reg  <= {num_reg[15:0], 1'b0};
                dcnt_reg <= dcnt_reg - 5'd1;
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= 10'(rem_sh - {1'b0, den_reg});
                    quo_reg <= {quo_reg[7:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[9:0];
                    quo_reg <= {quo_reg[7:0], 1'b0};
                end
            end
            else if (dbusy_reg)
            begin
                dbusy_reg           <= 1'b0;
                result_valid        <= 1'b1;
                result.is_pixel     <= 1'b1;
                result.scaled_value <= quo_reg[8] ? 8'hFF : quo_reg[7:0];
                result.pixel_index  <= 16'(oidx_reg);
                result.status       <= ST_OK;
                result.last_pixel   <= (oidx_reg + CW'(1) == cnt_reg);
                ridx_reg            <= ridx_reg + CW'(1);
                if (oidx_reg + CW'(1) == cnt_reg)
                    ready_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/min_max_contrast_stretch_top.sv
// ---------------------------------------------------------------------------
// min_max_contrast_stretch_top: 8-bit min/max contrast stretch
// Loads a grey frame into a store with running min/max, reports a frame
// status, then drains stretched pixels one per drain transaction.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  item in   start & !busy          item (in_item_t)
//  result    result_valid strobe    result (out_item_t), one cycle
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
//  A load with end of frame also closes the frame and strobes its status.
//  A drain reads the store and runs the 17-step restoring divider; a drain
//  with no frame ready strobes a no-frame status instead.
//  Reset clears statistics and flags; store contents are undefined.
//  The result strobe cannot be stalled; config is always ready.
// ---------------------------------------------------------------------------
`default_nettype none
module min_max_contrast_stretch_top #(
    parameter int unsigned FRAME_PIXELS = mmcs_pkg::FRAME_PIXELS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mmcs_pkg::in_item_t  item,
    output logic                    result_valid,
    output mmcs_pkg::out_item_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [10:0]        cfg_data
);
    import mmcs_pkg::*;

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [10:0] width_reg, height_reg;
    logic [8:0]  grey_reg;
    // item held for the cycle the load command executes
    in_item_t    item_q;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1;
            height_reg <= 11'd1;
            grey_reg   <= 9'd255;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_GREY:   grey_reg   <= cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    mmcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    mmcs_dp #(.FRAME_PIXELS(FRAME_PIXELS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_q),
        .cmd            (cmd),
        .frame_width    (width_reg),
        .frame_height   (height_reg),
        .max_grey_value (grey_reg),
        .sts            (sts),
        .result_valid   (result_valid),
        .result         (result)
    );

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_q <= item;
    end

endmodule
`default_nettype wire

// File: hw/rtl/mmcs_checker.sv
// ---------------------------------------------------------------------------
// mmcs_checker: port-level checks
// Watches the top level ports for strobe and status consistency.
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               result_valid,
    input wire mmcs_pkg::out_item_t result
);
    import mmcs_pkg::*;

    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("no busy after accept");

    a_pix_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_pixel) |-> (result.status == ST_OK))
        else $error("pixel with status");

    a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.is_pixel) |->
        (result.scaled_value == 8'd0 && result.last_pixel == 1'b0))
        else $error("status with pixel data");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result while idle");

endmodule

bind min_max_contrast_stretch_top mmcs_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

// File: tb/sv/min_max_contrast_stretch_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// min_max_contrast_stretch_top_tb: self-checking bench for contrast stretch
// Sends load and drain transactions through the start/busy port and checks
// every result strobe against an in-bench prediction of frame status and
// stretched pixels. Register writes happen only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none
module min_max_contrast_stretch_top_tb;
    import mmcs_pkg::*;

    // Small store keeps the overflow frame short.
    localparam int unsigned STORE_PIXELS = 256;
    // Index past the register list; a write there must change nothing.
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic        KIND_LOAD    = 1'b0;
    localparam logic        KIND_DRAIN   = 1'b1;
    localparam int          SETTLE_CYC   = 40;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          RANDOM_ITEMS = 1050;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   item = '0;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [10:0] cfg_data = '0;

    always #1 clk = ~clk;

    min_max_contrast_stretch_top #(.FRAME_PIXELS(STORE_PIXELS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // -----------------------------------------------------------------------
    // Predicted block state: registers, frame statistics, stored pixels
    // -----------------------------------------------------------------------
    logic [7:0]  pix_store [STORE_PIXELS];
    int unsigned img_w = 1, img_h = 1, grey_max = 255;
    int unsigned lo_val = 255, hi_val = 0, loaded = 0, drain_pos = 0;
    bit          range_bad = 0, drain_ok = 0, frame_done = 0;

    out_item_t   expected_q[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    bit          gaps_on = 1;

    task automatic open_frame();
        lo_val = 255; hi_val = 0; loaded = 0; range_bad = 0;
        drain_pos = 0; drain_ok = 0; frame_done = 0;
    endtask

    // Next state and any expected result of one accepted transaction.
    task automatic stretch_predict(input in_item_t it);
        out_item_t   r;
        int unsigned lim, px, span, ofs, v;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            lim = (grey_max > 255) ? 255 : grey_max;
            if (frame_done) open_frame();
            px = 32'(it.pixel_value);
            if (px > lim) range_bad = 1;
            else
            begin
                if (loaded < STORE_PIXELS) pix_store[loaded] = px[7:0];
                if (px < lo_val) lo_val = px;
                if (px > hi_val) hi_val = px;
            end
            if (loaded <= STORE_PIXELS) loaded++;
            if (!it.end_of_frame) return;
            if (range_bad)                 r.status = ST_RANGE;
            else if (loaded != img_w * img_h) r.status = ST_COUNT;
            else if (hi_val == lo_val)     r.status = ST_FLAT;
            else                           r.status = ST_OK;
            frame_done = 1;
            drain_ok   = (r.status == ST_OK);
            drain_pos  = 0;
        end
        else if (drain_ok && drain_pos < loaded && drain_pos < STORE_PIXELS
                 && hi_val > lo_val)
        begin
            px   = 32'(pix_store[drain_pos]);
            span = hi_val - lo_val;
            ofs  = (px >= lo_val) ? px - lo_val : 0;
            // round half up: (255*ofs/span + 1/2) in integers
            v    = (510 * ofs + span) / (2 * span);
            if (v > 255) v = 255;
            r.is_pixel     = 1'b1;
            r.scaled_value = v[7:0];
            r.pixel_index  = drain_pos[15:0];
            r.last_pixel   = (drain_pos + 1 == loaded);
            drain_pos++;
            if (r.last_pixel) drain_ok = 0;
        end
        else
            r.status = ST_NO_FRAME;
        expected_q = {expected_q, r};
    endtask

    // -----------------------------------------------------------------------
    // Driver tasks
    // -----------------------------------------------------------------------
    // One transaction; busy is sampled at the edge before the DUT updates it.
    task automatic send_item(input in_item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        stretch_predict(it);
        items_sent++;
        if (gaps_on && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_load(input int unsigned px, input bit eof);
        in_item_t it;
        it.kind = KIND_LOAD;
        it.pixel_value = px[15:0];
        it.end_of_frame = eof;
        send_item(it);
    endtask

    // Drain ticks carry random junk in the ignored fields.
    task automatic send_drain();
        in_item_t it;
        it.kind = KIND_DRAIN;
        it.pixel_value = 16'($urandom);
        it.end_of_frame = 1'($urandom_range(1));
        send_item(it);
    endtask

    // Hold off until every expected result has arrived, then let the
    // pipeline settle before touching registers.
    task automatic drain_wait();
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[10:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIDTH:  img_w    = val & 11'h7ff;
            REG_HEIGHT: img_h    = val & 11'h7ff;
            REG_GREY:   grey_max = val & 9'h1ff;
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned g);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_GREY, g);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Reset values: 1x1 frame, so a single pixel closes flat; drains say
    // no frame before and after.
    task automatic test_reset_values();
        send_drain();
        send_load(0, 1);
        send_drain();
        drain_wait();
    endtask

    task automatic test_directed();
        set_frame(2, 2, 255);
        // extremes, full drain plus one extra tick past the end
        send_load(0, 0); send_load(255, 0); send_load(128, 0); send_load(1, 1);
        repeat (5) send_drain();
        // new frame right after: bad value beats count mismatch
        send_load(65535, 1);
        drain_wait();
        // 256 counts as 255, so 255 passes and 256 fails
        set_frame(1, 2, 256);
        send_load(255, 0); send_load(3, 1);
        send_drain(); send_drain();
        send_load(256, 0); send_load(0, 1);
        drain_wait();
        // zero limit: only zeros fit, frame is flat
        write_reg(REG_GREY, 0);
        send_load(0, 0); send_load(0, 1);
        send_drain();
        drain_wait();
        // large 1024x1024 header, unknown register ignored
        set_frame(1024, 1024, 255);
        write_reg(REG_UNUSED, 11'h7ff);
        send_load(7, 0); send_load(200, 1);
        drain_wait();
    endtask

    // Store overflow: count saturates past the store, always a mismatch.
    task automatic test_store_overflow();
        set_frame(16, 16, 255);
        for (int i = 0; i < STORE_PIXELS + 3; i++)
            send_load($urandom_range(255), i == STORE_PIXELS + 2);
        send_drain();
        drain_wait();
    endtask

    task automatic test_random_frames();
        int unsigned w, h, g, lim, n, mode, bad_at;
        while (items_sent < RANDOM_ITEMS)
        begin
            // a long stretch with back-to-back transactions
            gaps_on = !(items_sent > 400 && items_sent < 650);
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 1024)
                                         : $urandom_range(1, 6);
            h = $urandom_range(1, 6);
            case ($urandom_range(3))
                0: g = 256;
                1: g = $urandom_range(256);
                default: g = 255;
            endcase
            set_frame(w, h, g);
            lim  = (g > 255) ? 255 : g;
            mode = $urandom_range(9);
            n    = w * h;
            if (mode == 7 || n > STORE_PIXELS)
                n = $urandom_range(1, 12);
            bad_at = (mode == 6) ? $urandom_range(n - 1) : n;
            for (int i = 0; i < n; i++)
            begin
                if (mode == 9 && $urandom_range(3) == 0) send_drain();
                if (i == bad_at && lim < 65535)
                    send_load($urandom_range(lim + 1, 65535), i == n - 1);
                else if (mode == 8)
                    send_load(lim, i == n - 1);
                else
                    send_load($urandom_range(lim), i == n - 1);
            end
            repeat (n + $urandom_range(2)) send_drain();
            if ($urandom_range(4) == 0) drain_wait();
            else
            begin
                start <= 1'b0;
                @(posedge clk);
                while (expected_q.size() != 0) @(posedge clk);
                repeat (SETTLE_CYC) @(posedge clk);
            end
        end
        gaps_on = 1;
    endtask

    // -----------------------------------------------------------------------
    // Result check: strobe is sampled at the edge that ends its cycle
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result.is_pixel !== e.is_pixel
                    || result.scaled_value !== e.scaled_value
                    || result.pixel_index !== e.pixel_index
                    || result.status !== e.status
                    || result.last_pixel !== e.last_pixel)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", e, result);
                end
            end
        end
    end

    // Watchdog: any accepted transaction, config write or result clears the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_store_overflow();
        test_random_frames();
        drain_wait();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/mmcs_pkg.sv
hw/rtl/mmcs_ctrl.sv
hw/rtl/mmcs_dp.sv
hw/rtl/min_max_contrast_stretch_top.sv
hw/rtl/mmcs_checker.sv
tb/sv/min_max_contrast_stretch_top_tb.sv
